// File: hw/rtl/cmdh_pkg.sv
// Shared types, constants and helper functions of the coverage map differ.
package cmdh_pkg;

	localparam logic [31:0] SEED_CONST = 32'ha5b35705;
	localparam logic [63:0] MUL_K1     = 64'h87c37b91114253d5;
	localparam logic [63:0] MUL_K2     = 64'h4cf5ad432745937f;
	localparam logic [63:0] ADD_H      = 64'h0000000052dce729;
	localparam logic [63:0] FMIX_1     = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_2     = 64'hc4ceb9fe1a85ec53;
	localparam logic [19:0] COUNT_MAX  = 20'hFFFFF;

	localparam logic [1:0] REG_MAP_LEN     = 2'd0;
	localparam logic [1:0] REG_WRITE_BACK  = 2'd1;
	localparam logic [1:0] REG_BUCKET_MODE = 2'd2;

	localparam logic OPC_DIFF  = 1'b0;
	localparam logic OPC_APPLY = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_START,
		DP_UPDATE,
		DP_MK1,
		DP_MK2,
		DP_MIXH,
		DP_TAIL,
		DP_MF1,
		DP_MF2,
		DP_FOUT,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic apply;
		logic full;
		logic last;
		logic mul_done;
		logic out_free;
	} dp_status_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [7:0] bucket_class(input logic [7:0] d, input logic binary);
		logic [7:0] k;
		if (binary) begin
			k = (d != 8'd0) ? 8'd1 : 8'd0;
		end else if (d <= 8'd2) begin
			k = d;
		end else if (d == 8'd3) begin
			k = 8'd4;
		end else if (d < 8'd8) begin
			k = 8'd8;
		end else if (d < 8'd16) begin
			k = 8'd16;
		end else if (d < 8'd32) begin
			k = 8'd32;
		end else if (d < 8'd128) begin
			k = 8'd64;
		end else begin
			k = 8'd128;
		end
		return k;
	endfunction

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(v[i]);
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/cmdh_in_if.sv
// Input channel: one map byte per transfer.
interface cmdh_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

// File: hw/rtl/cmdh_out_if.sv
// Output channel: one result per map byte.
interface cmdh_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        pass_done;
	logic [19:0] new_bit_count;
	logic [31:0] pass_hash;

	modport source (output valid, output byte_out, output pass_done,
		output new_bit_count, output pass_hash, input ready);
	modport sink (input valid, input byte_out, input pass_done,
		input new_bit_count, input pass_hash, output ready);
endinterface

// File: hw/rtl/cmdh_mul.sv
// 64x64 multiplier keeping the low 64 bits, one 32x32 partial product per cycle.
module cmdh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] res,
	output logic        done
);
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [2:0]  ph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 3'd0;
			a_q    <= 64'd0;
			b_q    <= 64'd0;
			prod_q <= 64'd0;
			acc_q  <= 64'd0;
		end else if (start) begin
			a_q  <= a;
			b_q  <= b;
			ph_q <= 3'd1;
		end else begin
			case (ph_q)
				3'd1: begin
					prod_q <= a_q[31:0] * b_q[31:0];
					ph_q   <= 3'd2;
				end
				3'd2: begin
					acc_q  <= prod_q;
					prod_q <= a_q[63:32] * b_q[31:0];
					ph_q   <= 3'd3;
				end
				3'd3: begin
					acc_q  <= acc_q + {prod_q[31:0], 32'd0};
					prod_q <= a_q[31:0] * b_q[63:32];
					ph_q   <= 3'd4;
				end
				3'd4: begin
					acc_q <= acc_q + {prod_q[31:0], 32'd0};
					ph_q  <= 3'd5;
				end
				default: ph_q <= 3'd0;
			endcase
		end
	end

	assign res  = acc_q;
	assign done = (ph_q == 3'd5);
endmodule

// File: hw/rtl/cmdh_dp.sv
// Datapath: seen map memory, bucketing, counters, hash state and output register.
module cmdh_dp #(
	parameter int SEEN_DEPTH = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmdh_pkg::dp_cmd_t    cmd,
	output cmdh_pkg::dp_status_t st,
	input  logic [16:0]          map_len,
	input  logic                 write_back,
	input  logic                 bucket_mode,
	input  logic                 opcode,
	input  logic [7:0]           data_byte,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [7:0]           byte_out,
	output logic                 pass_done,
	output logic [19:0]          new_bit_count,
	output logic [31:0]          pass_hash
);
	localparam int AW = $clog2(SEEN_DEPTH);
	localparam int LW = $clog2(SEEN_DEPTH + 1);

	logic [7:0]    seen_mem [SEEN_DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] idx_q;
	logic [LW-1:0] len_q;
	logic          mode_q;
	logic [19:0]   cnt_q;
	logic [63:0]   hash_q;
	logic [63:0]   word_q;
	logic [63:0]   blk_q;
	logic [7:0]    data_q;
	logic [7:0]    rd_q;
	logic [7:0]    res_byte_q;
	logic          res_done_q;
	logic [19:0]   res_cnt_q;
	logic [31:0]   res_hash_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_done_q;
	logic [19:0]   out_cnt_q;
	logic [31:0]   out_hash_q;

	logic [31:0]   len32;
	logic [31:0]   len_clamp;
	logic          last;
	logic [7:0]    kls;
	logic [7:0]    diff_byte;
	logic [20:0]   cnt_sum;
	logic [63:0]   new_word;
	logic [63:0]   mixed;
	logic [63:0]   fin;
	logic          mul_start;
	logic [63:0]   mul_a;
	logic [63:0]   mul_b;
	logic [63:0]   mul_res;
	logic          mul_done;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;

	assign len32 = {15'd0, map_len};
	always_comb begin
		len_clamp = len32;
		if (len32 == 32'd0) begin
			len_clamp = 32'd1;
		end else if (len32 > 32'(SEEN_DEPTH)) begin
			len_clamp = 32'(SEEN_DEPTH);
		end
	end

	assign last      = ((LW + 1)'(idx_q) + (LW + 1)'(1)) >= (LW + 1)'(len_q);
	assign kls       = cmdh_pkg::bucket_class(data_q, bucket_mode);
	assign diff_byte = kls & ~rd_q;
	assign cnt_sum   = {1'b0, cnt_q} + 21'(cmdh_pkg::popcount8(diff_byte));
	assign new_word  = word_q | (64'(diff_byte) << {idx_q[2:0], 3'b000});
	assign mixed     = cmdh_pkg::rotl64(hash_q ^ mul_res, 27);
	assign fin       = mul_res ^ (mul_res >> 33);

	always_comb begin
		mul_start = 1'b0;
		mul_a     = blk_q;
		mul_b     = cmdh_pkg::MUL_K1;
		case (cmd.op)
			cmdh_pkg::DP_MK1: begin
				mul_start = 1'b1;
			end
			cmdh_pkg::DP_MK2: begin
				mul_start = 1'b1;
				mul_a     = cmdh_pkg::rotl64(mul_res, 31);
				mul_b     = cmdh_pkg::MUL_K2;
			end
			cmdh_pkg::DP_MF1: begin
				mul_start = 1'b1;
				mul_a     = hash_q ^ (hash_q >> 33);
				mul_b     = cmdh_pkg::FMIX_1;
			end
			cmdh_pkg::DP_MF2: begin
				mul_start = 1'b1;
				mul_a     = fin;
				mul_b     = cmdh_pkg::FMIX_2;
			end
			default: ;
		endcase
	end

	cmdh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res),
		.done   (mul_done)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = rd_q ^ data_q;
		if (cmd.op == cmdh_pkg::DP_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_addr_q;
			mem_wdata = 8'd0;
		end else if (cmd.op == cmdh_pkg::DP_UPDATE) begin
			if (mode_q == cmdh_pkg::OPC_APPLY) begin
				mem_we = 1'b1;
			end else begin
				mem_we    = write_back;
				mem_wdata = rd_q | kls;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seen_mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == cmdh_pkg::DP_START) begin
			rd_q <= seen_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			idx_q       <= '0;
			len_q       <= LW'(SEEN_DEPTH);
			mode_q      <= cmdh_pkg::OPC_DIFF;
			cnt_q       <= 20'd0;
			hash_q      <= 64'd0;
			word_q      <= 64'd0;
			blk_q       <= 64'd0;
			data_q      <= 8'd0;
			res_byte_q  <= 8'd0;
			res_done_q  <= 1'b0;
			res_cnt_q   <= 20'd0;
			res_hash_q  <= 32'd0;
			out_valid_q <= 1'b0;
			out_byte_q  <= 8'd0;
			out_done_q  <= 1'b0;
			out_cnt_q   <= 20'd0;
			out_hash_q  <= 32'd0;
		end else begin
			if (cmd.op == cmdh_pkg::DP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				cmdh_pkg::DP_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
				end
				cmdh_pkg::DP_START: begin
					data_q <= data_byte;
					if (idx_q == '0) begin
						len_q  <= len_clamp[LW-1:0];
						mode_q <= opcode;
						cnt_q  <= 20'd0;
						word_q <= 64'd0;
						hash_q <= {32'd0, cmdh_pkg::SEED_CONST ^ len_clamp};
					end
				end
				cmdh_pkg::DP_UPDATE: begin
					res_done_q <= last;
					res_cnt_q  <= 20'd0;
					res_hash_q <= 32'd0;
					idx_q      <= last ? '0 : idx_q + AW'(1);
					if (mode_q == cmdh_pkg::OPC_APPLY) begin
						res_byte_q <= rd_q ^ data_q;
					end else begin
						res_byte_q <= diff_byte;
						cnt_q      <= cnt_sum[20] ? cmdh_pkg::COUNT_MAX : cnt_sum[19:0];
						if (idx_q[2:0] == 3'd7 || last) begin
							blk_q  <= new_word;
							word_q <= 64'd0;
						end else begin
							word_q <= new_word;
						end
					end
				end
				cmdh_pkg::DP_MIXH: begin
					hash_q <= (mixed << 2) + mixed + cmdh_pkg::ADD_H;
				end
				cmdh_pkg::DP_TAIL: begin
					blk_q <= word_q;
				end
				cmdh_pkg::DP_FOUT: begin
					res_cnt_q  <= cnt_q;
					res_hash_q <= fin[31:0];
				end
				cmdh_pkg::DP_EMIT: begin
					out_byte_q  <= res_byte_q;
					out_done_q  <= res_done_q;
					out_cnt_q   <= res_cnt_q;
					out_hash_q  <= res_hash_q;
				end
				default: ;
			endcase
		end
	end

	assign st = '{
		clr_last: (clr_addr_q == AW'(SEEN_DEPTH - 1)),
		apply:    (mode_q == cmdh_pkg::OPC_APPLY),
		full:     (idx_q[2:0] == 3'd7),
		last:     last,
		mul_done: mul_done,
		out_free: (!out_valid_q || out_ready)
	};

	assign out_valid     = out_valid_q;
	assign byte_out      = out_byte_q;
	assign pass_done     = out_done_q;
	assign new_bit_count = out_cnt_q;
	assign pass_hash     = out_hash_q;
endmodule

// File: hw/rtl/cmdh_ctrl.sv
// Controller: sequences clearing, per-byte update, block mixing and finalization.
module cmdh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cmdh_pkg::dp_status_t st,
	output cmdh_pkg::dp_cmd_t    cmd
);
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_UPD,
		S_MK1,
		S_WK1,
		S_MK2,
		S_WK2,
		S_MIXH,
		S_TAIL,
		S_MF1,
		S_WF1,
		S_MF2,
		S_WF2,
		S_FOUT,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   tail_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = cmdh_pkg::DP_NOP;
		unique case (state_q)
			S_CLEAR: cmd.op = cmdh_pkg::DP_CLEAR;
			S_IDLE:  cmd.op = in_valid ? cmdh_pkg::DP_START : cmdh_pkg::DP_NOP;
			S_UPD:   cmd.op = cmdh_pkg::DP_UPDATE;
			S_MK1:   cmd.op = cmdh_pkg::DP_MK1;
			S_MK2:   cmd.op = cmdh_pkg::DP_MK2;
			S_MIXH:  cmd.op = cmdh_pkg::DP_MIXH;
			S_TAIL:  cmd.op = cmdh_pkg::DP_TAIL;
			S_MF1:   cmd.op = cmdh_pkg::DP_MF1;
			S_MF2:   cmd.op = cmdh_pkg::DP_MF2;
			S_FOUT:  cmd.op = cmdh_pkg::DP_FOUT;
			S_EMIT:  cmd.op = st.out_free ? cmdh_pkg::DP_EMIT : cmdh_pkg::DP_NOP;
			default: cmd.op = cmdh_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			last_q  <= 1'b0;
			tail_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: if (st.clr_last) state_q <= S_IDLE;
				S_IDLE:  if (in_valid) state_q <= S_UPD;
				S_UPD: begin
					last_q <= st.last;
					tail_q <= st.last && st.full;
					if (!st.apply && (st.full || st.last)) begin
						state_q <= S_MK1;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_MK1: state_q <= S_WK1;
				S_WK1: if (st.mul_done) state_q <= S_MK2;
				S_MK2: state_q <= S_WK2;
				S_WK2: if (st.mul_done) state_q <= S_MIXH;
				S_MIXH: begin
					// a full last word still owes the empty tail block
					if (tail_q) begin
						state_q <= S_TAIL;
					end else if (last_q) begin
						state_q <= S_MF1;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_TAIL: begin
					tail_q  <= 1'b0;
					state_q <= S_MK1;
				end
				S_MF1: state_q <= S_WF1;
				S_WF1: if (st.mul_done) state_q <= S_MF2;
				S_MF2: state_q <= S_WF2;
				S_WF2: if (st.mul_done) state_q <= S_FOUT;
				S_FOUT: state_q <= S_EMIT;
				S_EMIT: if (st.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/coverage_map_diff_hash.sv
// Coverage map differ and hasher: takes one map byte per transfer and returns
// one result per byte; the next byte is taken once the current result sits in
// the output register. An ordinary byte passes through accept, memory update
// and result load, and waits while the output register stays full. Every eighth
// byte of a diff pass, and its last byte, also mix a 64-bit block through two
// 64x64 multiplies on one shared multiplier (3 partial products of 32x32 bits
// per multiply); a last byte that closes a full word also mixes the empty tail
// block. The last byte of a diff pass then also runs the final mix. After reset
// the seen map is cleared one entry per cycle, all SEEN_DEPTH entries, before
// the first byte is taken.
// Registers: map_len at 0x0, write_back at 0x4, bucket_mode at 0x8.
module coverage_map_diff_hash #(
	parameter int SEEN_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	cmdh_in_if.sink     in_ch,
	cmdh_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [16:0]          map_len_q;
	logic                 write_back_q;
	logic                 bucket_mode_q;
	cmdh_pkg::dp_cmd_t    cmd;
	cmdh_pkg::dp_status_t st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_len_q     <= 17'h10000;
			write_back_q  <= 1'b1;
			bucket_mode_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				cmdh_pkg::REG_MAP_LEN:     map_len_q <= pwdata[16:0];
				cmdh_pkg::REG_WRITE_BACK:  write_back_q <= pwdata[0];
				cmdh_pkg::REG_BUCKET_MODE: bucket_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			cmdh_pkg::REG_MAP_LEN:     prdata = {15'd0, map_len_q};
			cmdh_pkg::REG_WRITE_BACK:  prdata = {31'd0, write_back_q};
			cmdh_pkg::REG_BUCKET_MODE: prdata = {31'd0, bucket_mode_q};
			default:                   prdata = 32'd0;
		endcase
	end

	cmdh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	cmdh_dp #(
		.SEEN_DEPTH (SEEN_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.map_len       (map_len_q),
		.write_back    (write_back_q),
		.bucket_mode   (bucket_mode_q),
		.opcode        (in_ch.opcode),
		.data_byte     (in_ch.data_byte),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.byte_out      (out_ch.byte_out),
		.pass_done     (out_ch.pass_done),
		.new_bit_count (out_ch.new_bit_count),
		.pass_hash     (out_ch.pass_hash)
	);
endmodule
